// ----- rtl/core/pcmf_pkg.sv -----
// ----------------------------------------------------------------------------
// pcmf_pkg: shared types and constants of the PCM to float converter
// Register indexes, configuration record and the item passed between the
// front and back parts.
// ----------------------------------------------------------------------------
package pcmf_pkg;

	localparam int unsigned MAX_CHANNEL_COUNT = 16;
	localparam int unsigned MAX_FRAME_LENGTH  = 4096;
	localparam int unsigned CH_W  = $clog2(MAX_CHANNEL_COUNT);
	localparam int unsigned FR_W  = $clog2(MAX_FRAME_LENGTH);
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_ORDER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLANAR      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_CNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN   = 3'd4;

	localparam logic [1:0] MODE_16 = 2'd0;
	localparam logic [1:0] MODE_24 = 2'd1;

	typedef struct packed {
		logic [1:0]  sample_width_mode;
		logic        byte_order;
		logic        planar_output;
		logic [4:0]  channel_count;
		logic [12:0] frame_length;
	} cfg_t;

	// Classified item: sign-extended sample, its width mode and destination
	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  mode;
		logic [15:0] dest_index;
		logic        block_last;
	} item_t;

	localparam int unsigned ITEM_W = $bits(item_t);

endpackage

// ----- rtl/core/pcmf_stream_if.sv -----
// ----------------------------------------------------------------------------
// pcmf_stream_if: valid/ready channels of the converter
// Input, output and configuration channels.
// ----------------------------------------------------------------------------
interface pcmf_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] raw_sample;
	modport source (output valid, output raw_sample, input ready);
	modport sink (input valid, input raw_sample, output ready);
endinterface

interface pcmf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] float_bits;
	logic [15:0] dest_index;
	logic        block_last;
	modport source (output valid, output float_bits, output dest_index, output block_last,
		input ready);
	modport sink (input valid, input float_bits, input dest_index, input block_last,
		output ready);
endinterface

interface pcmf_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/pcm_to_float_converter_core.sv -----
// ----------------------------------------------------------------------------
// pcm_to_float_converter_core: PCM sample to IEEE single-precision converter
// Each input transaction carries one raw sample in memory byte order; each
// output transaction carries its float value, destination index and an
// end-of-block flag. The configuration channel writes the five registers
// (width mode, byte order, planar layout, channel count, frame length) by
// index, and should only be used while no sample is in flight.
// The front part assembles bytes and computes the destination index in the
// accepting cycle; a two-entry queue feeds the back part, whose two stages
// normalise and round, and a four-entry skid buffer drives the output.
// Output valid rises once a sample has passed the queue, stages and buffer;
// the block accepts one sample per cycle while the receiver keeps up, as the
// skid buffer covers every sample still in the back part's pipeline.
// When the receiver stalls, the queue and buffer fill and ready falls; no
// transaction is lost. Reset clears the counters, pipelines and queues and
// loads the register defaults: 16-bit, little-endian, interleaved, two
// channels, 1024 frames.
// ----------------------------------------------------------------------------
module pcm_to_float_converter_core (
	input  logic     clk,
	input  logic     arst_n,
	pcmf_cfg_if.sink cfg_ch,
	pcmf_in_if.sink  in_ch,
	pcmf_out_if.source out_ch
);
	import pcmf_pkg::*;

	cfg_t  cfg_q;
	item_t f_item;
	item_t b_item;
	logic  q_ready;
	logic  b_valid;
	logic  b_ready;
	logic  in_fire;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_width_mode <= 2'd0;
			cfg_q.byte_order        <= 1'b1;
			cfg_q.planar_output     <= 1'b0;
			cfg_q.channel_count     <= 5'd2;
			cfg_q.frame_length      <= 13'd1024;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_WIDTH_MODE:  cfg_q.sample_width_mode <= cfg_ch.data[1:0];
				REG_BYTE_ORDER:  cfg_q.byte_order        <= cfg_ch.data[0];
				REG_PLANAR:      cfg_q.planar_output     <= cfg_ch.data[0];
				REG_CHANNEL_CNT: cfg_q.channel_count     <= cfg_ch.data[4:0];
				REG_FRAME_LEN:   cfg_q.frame_length      <= cfg_ch.data[12:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = q_ready;
	assign in_fire = in_ch.valid && q_ready;

	pcmf_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .in_fire(in_fire),
		.raw_sample(in_ch.raw_sample), .item(f_item)
	);

	pcmf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(in_ch.valid), .wr_ready(q_ready),
		.wr_item(f_item), .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
	);

	pcmf_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(b_valid), .in_ready(b_ready),
		.in_item(b_item), .out_ch(out_ch)
	);

endmodule

// ----- rtl/core/pcmf_front.sv -----
// ----------------------------------------------------------------------------
// pcmf_front: byte assembly and destination indexing
// Orders the bytes, sign-extends, and keeps the channel and frame counters.
// ----------------------------------------------------------------------------
module pcmf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  pcmf_pkg::cfg_t      cfg,
	input  logic                in_fire,
	input  logic [31:0]         raw_sample,
	output pcmf_pkg::item_t     item
);
	import pcmf_pkg::*;

	logic [CH_W-1:0] ch_q;
	logic [FR_W-1:0] fr_q;
	logic [CH_W:0]   cc;
	logic [FR_W:0]   fl;
	logic [31:0]     val;
	logic [31:0]     sw;
	logic            ch_wrap;
	logic            fr_wrap;
	logic [31:0]     pidx;

	always_comb begin
		if (cfg.channel_count == 5'd0) cc = (CH_W+1)'(1);
		else if (32'(cfg.channel_count) > MAX_CHANNEL_COUNT) cc = (CH_W+1)'(MAX_CHANNEL_COUNT);
		else cc = (CH_W+1)'(cfg.channel_count);
		if (cfg.frame_length == 13'd0) fl = (FR_W+1)'(1);
		else if (32'(cfg.frame_length) > MAX_FRAME_LENGTH) fl = (FR_W+1)'(MAX_FRAME_LENGTH);
		else fl = (FR_W+1)'(cfg.frame_length);
	end

	always_comb begin
		sw = {raw_sample[7:0], raw_sample[15:8], raw_sample[23:16], raw_sample[31:24]};
		case (cfg.sample_width_mode)
			MODE_16: begin
				val = cfg.byte_order ? {{16{raw_sample[15]}}, raw_sample[15:0]}
					: {{16{raw_sample[7]}}, raw_sample[7:0], raw_sample[15:8]};
			end
			MODE_24: begin
				val = cfg.byte_order ? {{8{raw_sample[23]}}, raw_sample[23:0]}
					: {{8{raw_sample[7]}}, raw_sample[7:0], raw_sample[15:8],
						raw_sample[23:16]};
			end
			default: val = cfg.byte_order ? raw_sample : sw;
		endcase
	end

	assign ch_wrap = (32'(ch_q) + 32'd1) >= 32'(cc);
	assign fr_wrap = (32'(fr_q) + 32'd1) >= 32'(fl);
	assign pidx = cfg.planar_output ? 32'(ch_q) * 32'(fl) + 32'(fr_q)
		: 32'(fr_q) * 32'(cc) + 32'(ch_q);

	always_comb begin
		item.value      = val;
		item.mode       = cfg.sample_width_mode;
		item.dest_index = pidx[15:0];
		item.block_last = ch_wrap && fr_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
			fr_q <= '0;
		end else if (in_fire) begin
			if (ch_wrap) begin
				ch_q <= '0;
				fr_q <= fr_wrap ? '0 : fr_q + 1'b1;
			end else begin
				ch_q <= ch_q + 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/pcmf_queue.sv -----
// ----------------------------------------------------------------------------
// pcmf_queue: two-entry queue between front and back
// Lets the front accept while the back is stalled.
// ----------------------------------------------------------------------------
module pcmf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  pcmf_pkg::item_t wr_item,
	output logic            rd_valid,
	input  logic            rd_ready,
	output pcmf_pkg::item_t rd_item
);
	import pcmf_pkg::*;

	item_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       wr;
	logic       rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_item  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

// ----- rtl/core/pcmf_back.sv -----
// ----------------------------------------------------------------------------
// pcmf_back: integer to single-precision conversion
// Stage one finds the leading one and normalises, stage two rounds and packs;
// a four-entry skid buffer feeds the output channel.
// ----------------------------------------------------------------------------
module pcmf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pcmf_pkg::item_t in_item,
	pcmf_out_if.source      out_ch
);
	import pcmf_pkg::*;

	typedef struct packed {
		logic        sign;
		logic        zero;
		logic [4:0]  p;
		logic [31:0] norm;
		logic [4:0]  fbits;
		logic [15:0] dest_index;
		logic        block_last;
	} norm_t;

	typedef struct packed {
		logic [31:0] float_bits;
		logic [15:0] dest_index;
		logic        block_last;
	} res_t;

	norm_t       n_d;
	norm_t       n_s1;
	logic        v_s1;
	res_t        r_d;
	res_t        r_s2;
	logic        v_s2;
	res_t        buf_q [4];
	logic [1:0]  wp_q;
	logic [1:0]  rp_q;
	logic [2:0]  cnt_q;
	logic [31:0] mag;
	logic [4:0]  lz;
	logic        adv;
	logic        pop;
	logic [2:0]  inflight;
	logic [24:0] q;
	logic        rnd;
	logic [7:0]  e;
	logic [24:0] qr;

	always_comb begin
		mag = in_item.value[31] ? (~in_item.value + 32'd1) : in_item.value;
		lz = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (mag[i]) lz = 5'(i);
		end
		n_d.sign       = in_item.value[31];
		n_d.zero       = in_item.value == 32'd0;
		n_d.p          = lz;
		n_d.norm       = mag << (5'd31 - lz);
		case (in_item.mode)
			MODE_16: n_d.fbits = 5'd15;
			MODE_24: n_d.fbits = 5'd23;
			default: n_d.fbits = 5'd31;
		endcase
		n_d.dest_index = in_item.dest_index;
		n_d.block_last = in_item.block_last;
	end

	// Slots held by the pipeline and buffer never exceed four, so the skid
	// buffer cannot overflow.
	assign inflight = 3'(v_s1) + 3'(v_s2) + cnt_q - 3'(pop);
	assign in_ready = inflight < 3'd4;
	assign adv      = in_valid && in_ready;

	always_comb begin
		q   = {1'b0, n_s1.norm[31:8]};
		rnd = n_s1.norm[7] && ((n_s1.norm[6:0] != 7'd0) || n_s1.norm[8]);
		qr  = q + 25'(rnd);
		e   = 8'(8'd127 + 8'(n_s1.p) - 8'(n_s1.fbits));
		if (qr[24]) begin
			e  = e + 8'd1;
			qr = qr >> 1;
		end
		r_d.float_bits = n_s1.zero ? 32'd0 : {n_s1.sign, e, qr[22:0]};
		r_d.dest_index = n_s1.dest_index;
		r_d.block_last = n_s1.block_last;
	end

	always_ff @(posedge clk) begin
		if (adv) n_s1 <= n_d;
		if (v_s1) r_s2 <= r_d;
		if (v_s2) buf_q[wp_q] <= r_s2;
	end

	assign pop = out_ch.valid && out_ch.ready;
	assign out_ch.valid      = cnt_q != 3'd0;
	assign out_ch.float_bits = buf_q[rp_q].float_bits;
	assign out_ch.dest_index = buf_q[rp_q].dest_index;
	assign out_ch.block_last = buf_q[rp_q].block_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			v_s1 <= adv;
			v_s2 <= v_s1;
			if (v_s2) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(v_s2) - 3'(pop);
		end
	end

endmodule
